### design/sgp_pkg.sv
// Shared codes, register indexes and fixed widths for the swipe gesture playback block.
package sgp_pkg;

  localparam int ACTION_W = 2;
  localparam int THRESH_W = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_INDEX_W = 1;

  localparam logic [ACTION_W-1:0] ACT_DOWN = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_UP   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_TICK = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_ENABLE    = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 1'd1;

  localparam int PHASE_W = 2;
  localparam logic [PHASE_W-1:0] PH_IDLE = 2'd0;
  localparam logic [PHASE_W-1:0] PH_DOWN = 2'd1;
  localparam logic [PHASE_W-1:0] PH_MOVE = 2'd2;
  localparam logic [PHASE_W-1:0] PH_DONE = 2'd3;

  typedef logic [ACTION_W-1:0] action_t;

endpackage

### design/sgp_if.sv
// Valid/ready channel interfaces for finger events and touch contact beats.
interface sgp_event_if
  import sgp_pkg::*;
#(
  parameter int COORD_BITS = 16
);
  logic                  valid;
  logic                  ready;
  action_t               action;
  logic [COORD_BITS-1:0] pos_x;
  logic [COORD_BITS-1:0] pos_y;

  modport source (output valid, output action, output pos_x, output pos_y, input ready);
  modport sink (input valid, input action, input pos_x, input pos_y, output ready);
endinterface

interface sgp_touch_if #(
  parameter int FRAC_BITS = 10
);
  logic                 valid;
  logic                 ready;
  logic                 touch_write;
  logic                 touch_down;
  logic [FRAC_BITS-1:0] touch_x;
  logic [FRAC_BITS-1:0] touch_y;
  logic                 button_write;
  logic                 button_pressed;

  modport source (output valid, output touch_write, output touch_down, output touch_x,
                  output touch_y, output button_write, output button_pressed, input ready);
  modport sink (input valid, input touch_write, input touch_down, input touch_x,
                input touch_y, input button_write, input button_pressed, output ready);
endinterface

### design/swipe_gesture_playback.sv
// Eight-direction swipe recognizer that replays each gesture as touch contact beats.
//
// The block takes one event beat per cycle (finger down, finger up or poll tick) and
// delivers at most one touch contact beat for it. An accepted event is held in the input
// register, and from there the block works out the displacement from the stored start
// point, the three products |dx|^2, |dy|^2 and |dx|*|dy| in parallel multipliers, the
// distance and sector compares, and the next gesture state. The rising edge that moves
// the input register on updates the gesture state and loads the result register that
// drives the contact channel; an event goes through the input and result registers.
// Events flow at one per cycle as long as the result register is empty or
// being taken. When a result waits unclaimed, the input register holds and event ready
// drops. A finger-up that moves at least the threshold is snapped to one of eight
// 45-degree sectors with exact integer compares; a shorter one is a tap at the centre.
// Enabled ticks then play back the gesture: HOLD_FRAMES pressed beats at the centre
// with the click button down, HOLD_FRAMES beats at the endpoint, then a release. A
// finger-down during playback cancels it with a release beat. Configuration writes are
// taken at any edge where cfg_we is high and must only be made while no event is in
// flight.
module swipe_gesture_playback
  import sgp_pkg::*;
#(
  parameter int COORD_BITS  = 16,
  parameter int FRAC_BITS   = 10,
  parameter int HOLD_FRAMES = 2
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  sgp_event_if.sink              gesture,
  sgp_touch_if.source            contact
);

  localparam int W        = COORD_BITS;
  localparam int PROD_W   = 2 * W;
  localparam int SUM_W    = 2 * W + 2;
  localparam int THR_SQ_W = 2 * THRESH_W;
  localparam int CMP_W    = (SUM_W > THR_SQ_W) ? SUM_W : THR_SQ_W;
  localparam int FC_W     = $clog2(HOLD_FRAMES + 1);

  localparam logic [FRAC_BITS-1:0] Q_CENTRE = FRAC_BITS'(1 << (FRAC_BITS - 1));
  localparam logic [FRAC_BITS-1:0] Q_HIGH   = FRAC_BITS'((18 * (1 << FRAC_BITS) + 10) / 20);
  localparam logic [FRAC_BITS-1:0] Q_LOW    = FRAC_BITS'((2 * (1 << FRAC_BITS) + 10) / 20);
  localparam logic [FC_W-1:0]      HOLD_LAST = FC_W'(HOLD_FRAMES);

  // The input register moves whenever the result register can take a new value.
  logic adv;
  assign adv = !contact.valid || contact.ready;
  assign gesture.ready = adv;

  // Configuration registers and the squared threshold.
  logic                swipe_enable;
  logic [THRESH_W-1:0] distance_threshold;
  logic [THR_SQ_W-1:0] thr_sq;

  // Gesture state.
  logic                 finger_active;
  logic [W-1:0]         start_x;
  logic [W-1:0]         start_y;
  logic [PHASE_W-1:0]   playback_phase;
  logic [FC_W-1:0]      frame_count;
  logic [FRAC_BITS-1:0] end_x;
  logic [FRAC_BITS-1:0] end_y;

  // Input register.
  logic         a_valid;
  action_t      a_action;
  logic [W-1:0] a_px;
  logic [W-1:0] a_py;

  // Displacement and decision. With a = |dx| and b = |dy|, the move is horizontal
  // when a^2 > 2ab + b^2 and vertical when b^2 > 2ab + a^2; anything else is diagonal.
  logic                 xneg;
  logic                 yneg;
  logic [W-1:0]         abs_x;
  logic [W-1:0]         abs_y;
  logic [PROD_W-1:0]    aa;
  logic [PROD_W-1:0]    bb;
  logic [PROD_W-1:0]    ab;
  logic [SUM_W-1:0]     dist2;
  logic [SUM_W-1:0]     horiz_rhs;
  logic [SUM_W-1:0]     vert_rhs;
  logic                 is_zero;
  logic                 is_swipe;
  logic                 horiz;
  logic                 vert;
  logic [FRAC_BITS-1:0] sect_x;
  logic [FRAC_BITS-1:0] sect_y;

  always_comb begin
    thr_sq    = THR_SQ_W'(distance_threshold) * THR_SQ_W'(distance_threshold);
    xneg      = a_px < start_x;
    yneg      = a_py < start_y;
    abs_x     = xneg ? (start_x - a_px) : (a_px - start_x);
    abs_y     = yneg ? (start_y - a_py) : (a_py - start_y);
    aa        = PROD_W'(abs_x) * PROD_W'(abs_x);
    bb        = PROD_W'(abs_y) * PROD_W'(abs_y);
    ab        = PROD_W'(abs_x) * PROD_W'(abs_y);
    dist2     = SUM_W'(aa) + SUM_W'(bb);
    horiz_rhs = (SUM_W'(ab) << 1) + SUM_W'(bb);
    vert_rhs  = (SUM_W'(ab) << 1) + SUM_W'(aa);
    is_zero   = (abs_x == '0) && (abs_y == '0);
    is_swipe  = CMP_W'(dist2) >= CMP_W'(thr_sq);
    horiz     = SUM_W'(aa) > horiz_rhs;
    vert      = SUM_W'(bb) > vert_rhs;
    if (is_zero) begin
      // A zero move that still counts as a swipe goes to the right.
      sect_x = Q_HIGH;
      sect_y = Q_CENTRE;
    end else if (horiz) begin
      sect_x = xneg ? Q_LOW : Q_HIGH;
      sect_y = Q_CENTRE;
    end else if (vert) begin
      sect_x = Q_CENTRE;
      sect_y = yneg ? Q_LOW : Q_HIGH;
    end else begin
      sect_x = xneg ? Q_LOW : Q_HIGH;
      sect_y = yneg ? Q_LOW : Q_HIGH;
    end
  end

  // Gesture state machine and result selection for the event in the input register.
  logic                 finger_next;
  logic [PHASE_W-1:0]   phase_next;
  logic [FC_W-1:0]      frame_next;
  logic [FC_W-1:0]      frame_inc;
  logic [FRAC_BITS-1:0] end_x_next;
  logic [FRAC_BITS-1:0] end_y_next;
  logic                 res_valid;
  logic                 res_down;
  logic [FRAC_BITS-1:0] res_x;
  logic [FRAC_BITS-1:0] res_y;
  logic                 res_bw;
  logic                 res_bp;

  always_comb begin
    finger_next = finger_active;
    phase_next  = playback_phase;
    frame_next  = frame_count;
    end_x_next  = end_x;
    end_y_next  = end_y;
    frame_inc   = frame_count + FC_W'(1);
    res_valid   = 1'b0;
    res_down    = 1'b0;
    res_x       = end_x;
    res_y       = end_y;
    res_bw      = 1'b0;
    res_bp      = 1'b0;
    if (a_valid) begin
      unique case (a_action)
        ACT_DOWN: begin
          if (playback_phase != PH_IDLE) begin
            // Cancel playback with a release at the stored endpoint.
            res_valid  = 1'b1;
            res_bw     = 1'b1;
            phase_next = PH_IDLE;
          end
          finger_next = 1'b1;
        end
        ACT_UP: begin
          if (finger_active) begin
            finger_next = 1'b0;
            end_x_next  = is_swipe ? sect_x : Q_CENTRE;
            end_y_next  = is_swipe ? sect_y : Q_CENTRE;
            phase_next  = PH_DOWN;
            frame_next  = '0;
          end
        end
        ACT_TICK: begin
          if (swipe_enable) begin
            unique case (playback_phase)
              PH_DOWN: begin
                res_valid = 1'b1;
                res_down  = 1'b1;
                res_x     = Q_CENTRE;
                res_y     = Q_CENTRE;
                res_bw    = 1'b1;
                res_bp    = 1'b1;
                if (frame_inc >= HOLD_LAST) begin
                  phase_next = PH_MOVE;
                  frame_next = '0;
                end else begin
                  frame_next = frame_inc;
                end
              end
              PH_MOVE: begin
                res_valid = 1'b1;
                res_down  = 1'b1;
                if (frame_inc >= HOLD_LAST) begin
                  phase_next = PH_DONE;
                  frame_next = '0;
                end else begin
                  frame_next = frame_inc;
                end
              end
              PH_DONE: begin
                res_valid  = 1'b1;
                res_bw     = 1'b1;
                phase_next = PH_IDLE;
              end
              default: begin
              end
            endcase
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      swipe_enable       <= 1'b0;
      distance_threshold <= THRESH_W'(15);
      finger_active      <= 1'b0;
      start_x            <= '0;
      start_y            <= '0;
      playback_phase     <= PH_IDLE;
      frame_count        <= '0;
      end_x              <= Q_CENTRE;
      end_y              <= Q_CENTRE;
      a_valid            <= 1'b0;
      contact.valid      <= 1'b0;
    end else begin
      if (adv) begin
        a_valid        <= gesture.valid;
        contact.valid  <= res_valid;
        finger_active  <= finger_next;
        playback_phase <= phase_next;
        frame_count    <= frame_next;
        end_x          <= end_x_next;
        end_y          <= end_y_next;
        if (a_valid && a_action == ACT_DOWN) begin
          start_x <= a_px;
          start_y <= a_py;
        end
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ENABLE: begin
            swipe_enable <= cfg_data[0];
            if (!cfg_data[0]) begin
              finger_active <= 1'b0;
            end
          end
          REG_THRESHOLD: begin
            distance_threshold <= cfg_data[THRESH_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (adv) begin
      if (gesture.valid) begin
        a_action <= gesture.action;
        a_px     <= gesture.pos_x;
        a_py     <= gesture.pos_y;
      end
      if (res_valid) begin
        contact.touch_down     <= res_down;
        contact.touch_x        <= res_x;
        contact.touch_y        <= res_y;
        contact.button_write   <= res_bw;
        contact.button_pressed <= res_bp;
      end
    end
  end

  // Every contact beat updates the touch state.
  assign contact.touch_write = 1'b1;

endmodule

### design/sgp_checker.sv
// Port-level checks on the contact channel of the swipe gesture playback block.
module sgp_checker #(
  parameter int FRAC_BITS = 10
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 valid,
  input logic                 ready,
  input logic                 touch_write,
  input logic                 touch_down,
  input logic [FRAC_BITS-1:0] touch_x,
  input logic [FRAC_BITS-1:0] touch_y,
  input logic                 button_write,
  input logic                 button_pressed
);

  localparam logic [FRAC_BITS-1:0] CENTRE = FRAC_BITS'(1 << (FRAC_BITS - 1));

  // A beat that waits keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(touch_down) && $stable(touch_x)
      && $stable(touch_y) && $stable(button_write) && $stable(button_pressed))
    else $error("contact beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !valid)
    else $error("contact beat presented right after reset");

  a_write: assert property (@(posedge clk) disable iff (rst) valid |-> touch_write)
    else $error("contact beat without touch update");

  // The click is only pressed during the centre hold frames.
  a_click_centre: assert property (@(posedge clk) disable iff (rst)
    valid && button_pressed |-> button_write && touch_down
      && touch_x == CENTRE && touch_y == CENTRE)
    else $error("click pressed away from a centre press frame");

  // Every release also releases the click button.
  a_release: assert property (@(posedge clk) disable iff (rst)
    valid && !touch_down |-> button_write && !button_pressed)
    else $error("release beat without button release");

endmodule

bind swipe_gesture_playback sgp_checker #(.FRAC_BITS(FRAC_BITS)) u_sgp_checker (
  .clk            (clk),
  .rst            (rst),
  .valid          (contact.valid),
  .ready          (contact.ready),
  .touch_write    (contact.touch_write),
  .touch_down     (contact.touch_down),
  .touch_x        (contact.touch_x),
  .touch_y        (contact.touch_y),
  .button_write   (contact.button_write),
  .button_pressed (contact.button_pressed)
);
